/* hdl/ald_pkg.sv */
// Shared types and constants for the ambient light dimmer.
`timescale 1ns / 1ps
package ald_pkg;

	localparam int ADDR_W    = 4;
	localparam int LUX_W     = 16;
	localparam int HOUR_W    = 5;
	localparam int CNT_W     = 5;
	localparam int PER_W     = 8;
	localparam int LVL_W     = 8;
	localparam int NUM_W     = 21;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W    = 5;

	localparam logic [1:0] REG_AVG_COUNT    = 2'd0;
	localparam logic [1:0] REG_WINDOW_START = 2'd1;
	localparam logic [1:0] REG_WINDOW_END   = 2'd2;
	localparam logic [1:0] REG_ADJ_PERIOD   = 2'd3;

	localparam logic [CNT_W-1:0]  RST_AVG_COUNT    = 5'd2;
	localparam logic [HOUR_W-1:0] RST_WINDOW_START = 5'd17;
	localparam logic [HOUR_W-1:0] RST_WINDOW_END   = 5'd23;
	localparam logic [PER_W-1:0]  RST_ADJ_PERIOD   = 8'd2;

	typedef struct packed {
		logic [CNT_W-1:0]  avg_count;
		logic [HOUR_W-1:0] window_start_hour;
		logic [HOUR_W-1:0] window_end_hour;
		logic [PER_W-1:0]  adjust_period;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic avg_wr;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic lux_phase;
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

/* hdl/ald_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ald_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ald_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output ald_pkg::cfg_t              cfg
);
	import ald_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.avg_count         <= RST_AVG_COUNT;
			cfg_q.window_start_hour <= RST_WINDOW_START;
			cfg_q.window_end_hour   <= RST_WINDOW_END;
			cfg_q.adjust_period     <= RST_ADJ_PERIOD;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_AVG_COUNT:    cfg_q.avg_count         <= pwdata[CNT_W-1:0];
				REG_WINDOW_START: cfg_q.window_start_hour <= pwdata[HOUR_W-1:0];
				REG_WINDOW_END:   cfg_q.window_end_hour   <= pwdata[HOUR_W-1:0];
				REG_ADJ_PERIOD:   cfg_q.adjust_period     <= pwdata[PER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_AVG_COUNT:    prdata = {{(32-CNT_W){1'b0}}, cfg_q.avg_count};
			REG_WINDOW_START: prdata = {{(32-HOUR_W){1'b0}}, cfg_q.window_start_hour};
			REG_WINDOW_END:   prdata = {{(32-HOUR_W){1'b0}}, cfg_q.window_end_hour};
			REG_ADJ_PERIOD:   prdata = {{(32-PER_W){1'b0}}, cfg_q.adjust_period};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

/* hdl/ald_ctrl.sv */
// Sequencing state machine for one tick: load, average update (lux ticks only), decision.
`timescale 1ns / 1ps
module ald_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  ald_pkg::sts_t sts,
	output ald_pkg::cmd_t cmd
);
	import ald_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_AVG    = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.lux_phase ? S_MUL : S_DECIDE;
				end
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nxt = S_AVG;
			end
			S_AVG: begin
				cmd.avg_wr = 1'b1;
				state_nxt  = S_DECIDE;
			end
			S_DECIDE: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

/* hdl/ald_dp.sv */
// Datapath: tick state, running average with serial divider, level stepping, output beat.
`timescale 1ns / 1ps
module ald_dp #(
	parameter int MAX_LEVEL = 255
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ald_pkg::cfg_t              cfg,
	input  ald_pkg::cmd_t              cmd,
	output ald_pkg::sts_t              sts,
	input  logic [ald_pkg::LUX_W-1:0]  lux_reading,
	input  logic [ald_pkg::HOUR_W-1:0] clock_hour,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ald_pkg::LVL_W-1:0]  drive_value,
	output logic                       blanked
);
	import ald_pkg::*;

	localparam logic [LVL_W-1:0] LVL_LIM = (MAX_LEVEL > 255) ? 8'd255 : LVL_W'(MAX_LEVEL);
	localparam logic [LVL_W-1:0] MAX_LO  = LVL_W'(MAX_LEVEL);

	logic              phase_q;
	logic [LUX_W-1:0]  avg_q;
	logic [HOUR_W-1:0] hour_q;
	logic [PER_W-1:0]  tick_q;
	logic [LVL_W-1:0]  level_q;
	logic [LUX_W-1:0]  lux_q;
	logic [CNT_W-1:0]  n_q;
	logic [NUM_W-1:0]  num_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [LVL_W-1:0]  drive_q;
	logic              blanked_q;

	logic [NUM_W-1:0]  numer;
	logic [CNT_W:0]    rem_sh;
	logic              rem_ge;
	logic [CNT_W:0]    rem_sub;
	logic              in_window;
	logic              step_due;
	logic [LVL_W:0]    lvl_nxt;
	logic [LVL_W-1:0]  lvl_clamp;

	assign numer   = NUM_W'(avg_q) * NUM_W'(n_q - 5'd1) + NUM_W'(lux_q);
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign rem_ge  = (rem_sh >= {1'b0, n_q});
	assign rem_sub = rem_sh - {1'b0, n_q};

	assign in_window = (hour_q > cfg.window_start_hour) && (hour_q < cfg.window_end_hour);
	assign step_due  = (tick_q >= cfg.adjust_period);

	always_comb begin
		if ({1'b0, avg_q} > (LUX_W+1)'(level_q) + 17'd1)
			lvl_nxt = {1'b0, level_q} + 9'd1;
		else if (avg_q < LUX_W'(level_q))
			lvl_nxt = {1'b0, level_q} - 9'd1;
		else
			lvl_nxt = {1'b0, level_q};
		lvl_clamp = (lvl_nxt > {1'b0, LVL_LIM}) ? LVL_LIM : lvl_nxt[LVL_W-1:0];
	end

	assign sts.lux_phase = ~phase_q;
	assign sts.div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.out_busy  = out_valid_q & out_stall;

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign blanked     = blanked_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			avg_q       <= '0;
			hour_q      <= '0;
			tick_q      <= '0;
			level_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				phase_q <= ~phase_q;
				if (tick_q != '1)
					tick_q <= tick_q + 8'd1;
				if (phase_q)
					hour_q <= clock_hour;
			end
			if (cmd.mul)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + 5'd1;
			if (cmd.avg_wr)
				avg_q <= num_q[LUX_W-1:0];
			if (cmd.commit && in_window && step_due) begin
				level_q <= lvl_clamp;
				tick_q  <= '0;
			end
			if (cmd.commit && (!in_window || step_due))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lux_q <= lux_reading;
			n_q   <= (cfg.avg_count == '0) ? 5'd1 : cfg.avg_count;
		end
		if (cmd.mul) begin
			num_q <= numer;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
		if (cmd.commit) begin
			if (!in_window) begin
				drive_q   <= '0;
				blanked_q <= 1'b1;
			end else if (step_due) begin
				drive_q   <= MAX_LO - lvl_clamp;
				blanked_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/ambient_light_dimmer.sv */
// Top level of the ambient light dimmer: config port, controller and datapath.
// Order: a clock-phase tick goes load, decide; a lux-phase tick goes load, multiply,
// restoring divider (21 one-bit steps), average, decide (held by a stalled beat).
// Throughput: one tick at a time; in_stall holds new input until decide commits.
// Reset: arst_n clears control state, not payload; loads defaults; no clearing pass.
`timescale 1ns / 1ps
module ambient_light_dimmer #(
	parameter int MAX_LEVEL = 255
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ald_pkg::LUX_W-1:0]  lux_reading,
	input  logic [ald_pkg::HOUR_W-1:0] clock_hour,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ald_pkg::LVL_W-1:0]  drive_value,
	output logic                       blanked,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ald_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ald_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	ald_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ald_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ald_dp #(
		.MAX_LEVEL (MAX_LEVEL)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.lux_reading (lux_reading),
		.clock_hour  (clock_hour),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_value (drive_value),
		.blanked     (blanked)
	);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after input beat");

	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blanked |-> drive_value == '0)
		else $error("blanked beat with nonzero drive");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without a tick in progress");

endmodule

/* dv/ambient_light_dimmer_tb.sv */
// Self-checking testbench for ambient_light_dimmer: tick stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps
module ambient_light_dimmer_tb;
	import ald_pkg::*;

	localparam int LEVEL_CEIL = 255;
	localparam int LEVEL_CAP  = (LEVEL_CEIL > 255) ? 255 : LEVEL_CEIL;
	localparam int SETTLE_CYC = 40;

	typedef struct packed {
		logic [LVL_W-1:0] drive;
		logic             blank;
	} dim_out_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [LUX_W-1:0]  lux_reading = '0;
	logic [HOUR_W-1:0] clock_hour  = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [LVL_W-1:0]  drive_value;
	logic              blanked;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [ADDR_W-1:0] paddr       = '0;
	logic [31:0]       pwdata      = '0;
	logic [31:0]       prdata;
	logic              pready;

	ambient_light_dimmer #(.MAX_LEVEL(LEVEL_CEIL)) dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register mirror
	logic [CNT_W-1:0]  cfg_avg    = RST_AVG_COUNT;
	logic [HOUR_W-1:0] cfg_start  = RST_WINDOW_START;
	logic [HOUR_W-1:0] cfg_end    = RST_WINDOW_END;
	logic [PER_W-1:0]  cfg_period = RST_ADJ_PERIOD;

	// dimmer state
	logic              m_clock_phase = 1'b0;
	logic [LUX_W-1:0]  m_avg         = '0;
	logic [HOUR_W-1:0] m_hour        = '0;
	logic [7:0]        m_ticks       = '0;
	logic [LVL_W-1:0]  m_level       = '0;

	dim_out_t pending_drive[$];

	int mismatches = 0;
	int n_ticks    = 0;
	int n_writes   = 0;
	int n_blank    = 0;
	int n_steps    = 0;
	int peak_level = 0;

	bit tx_up     = 1'b0;
	int tx_burst  = 0;
	int tx_gap    = 1;
	bit rx_hold   = 1'b0;
	int rx_left   = 0;

	function automatic void dimmer_tick(input logic [LUX_W-1:0] lux,
			input logic [HOUR_W-1:0] hour);
		int unsigned weight;
		int unsigned lvl;
		if (m_ticks != 8'hFF)
			m_ticks = m_ticks + 8'd1;
		if (!m_clock_phase) begin
			weight = (cfg_avg == '0) ? 1 : cfg_avg;
			m_avg = LUX_W'((m_avg * (weight - 1) + lux) / weight);
			m_clock_phase = 1'b1;
		end else begin
			m_hour = hour;
			m_clock_phase = 1'b0;
		end
		if (!(m_hour > cfg_start && m_hour < cfg_end)) begin
			pending_drive.push_back('{drive: '0, blank: 1'b1});
		end else if (m_ticks >= cfg_period) begin
			lvl = m_level;
			if (m_avg > lvl + 1)
				lvl++;
			else if (m_avg < lvl)
				lvl--;
			if (lvl > LEVEL_CAP)
				lvl = LEVEL_CAP;
			m_level = LVL_W'(lvl);
			m_ticks = '0;
			if (lvl > peak_level)
				peak_level = lvl;
			pending_drive.push_back('{drive: LVL_W'(LEVEL_CEIL - lvl), blank: 1'b0});
		end
	endfunction

	function automatic void flag_field(input string field, input int want, input int got);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
	endfunction

	// scoreboard
	always @(posedge clk) begin
		dim_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t ns: unexpected beat, expected none actual drive %0d blanked %0d",
						$time, drive_value, blanked);
			end else begin
				want = pending_drive.pop_front();
				if (drive_value !== want.drive)
					flag_field("drive_value", want.drive, drive_value);
				if (blanked !== want.blank)
					flag_field("blanked", want.blank, blanked);
				if (want.blank)
					n_blank++;
				else
					n_steps++;
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_hold = ($urandom_range(0, 2) == 0);
			rx_left = rx_hold ? $urandom_range(1, 20) : $urandom_range(1, 40);
		end
		rx_left--;
		out_stall <= rx_hold;
	end

	task automatic send_tick(input logic [LUX_W-1:0] lux, input logic [HOUR_W-1:0] hour);
		if (!tx_up) begin
			repeat (tx_gap) @(negedge clk);
			tx_burst = $urandom_range(1, 24);
			tx_up = 1'b1;
			in_valid <= 1'b1;
		end
		lux_reading <= lux;
		clock_hour <= hour;
		do @(posedge clk); while (in_stall);
		dimmer_tick(lux, hour);
		n_ticks++;
		@(negedge clk);
		tx_burst--;
		if (tx_burst == 0) begin
			tx_up = 1'b0;
			in_valid <= 1'b0;
			tx_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
	endtask

	task automatic hold_sender();
		if (tx_up) begin
			tx_up = 1'b0;
			tx_gap = 1;
			in_valid <= 1'b0;
		end
	endtask

	task automatic wait_results();
		while (pending_drive.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_idle();
		hold_sender();
		wait_results();
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic maybe_pause();
		if ($urandom_range(0, 49) == 0) begin
			hold_sender();
			wait_results();
		end
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_AVG_COUNT:    cfg_avg = val[CNT_W-1:0];
			REG_WINDOW_START: cfg_start = val[HOUR_W-1:0];
			REG_WINDOW_END:   cfg_end = val[HOUR_W-1:0];
			REG_ADJ_PERIOD:   cfg_period = val[PER_W-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== val)
			flag_field("prdata", val, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [LUX_W-1:0] pick_lux();
		int v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = 65535;
			2, 3: begin
				v = int'(m_level) + int'($urandom_range(0, 3)) - 1;
				if (v < 0)
					v = 0;
			end
			default: v = $urandom_range(0, 65535);
		endcase
		return LUX_W'(v);
	endfunction

	function automatic logic [HOUR_W-1:0] pick_hour();
		int lo;
		int hi;
		lo = int'(cfg_start) + 1;
		hi = int'(cfg_end) - 1;
		if (hi >= lo && $urandom_range(0, 4) != 0)
			return HOUR_W'($urandom_range(lo, hi));
		return HOUR_W'($urandom_range(0, 31));
	endfunction

	task automatic test_default_window();
		send_tick(16'hFFFF, 5'd0);
		send_tick(16'h0000, 5'd18);
		send_tick(16'hFFFF, 5'd31);
		send_tick(16'h0000, 5'd31);
		send_tick(16'h0000, 5'd17);
		send_tick(16'h0000, 5'd17);
		send_tick(16'h8000, 5'd22);
		send_tick(16'h7FFF, 5'd22);
		drain_idle();
	endtask

	task automatic test_wide_window();
		cfg_write(REG_AVG_COUNT, 32'd1);
		cfg_write(REG_WINDOW_START, 32'd0);
		cfg_write(REG_WINDOW_END, 32'd24);
		cfg_write(REG_ADJ_PERIOD, 32'd1);
		send_tick(16'hFFFF, 5'd0);
		send_tick(16'h0000, 5'd0);
		send_tick(16'h0000, 5'd1);
		send_tick(16'hFFFF, 5'd23);
		send_tick(16'h0001, 5'd16);
		send_tick(16'h0002, 5'd16);
		drain_idle();
	endtask

	task automatic test_zero_settings();
		cfg_write(REG_AVG_COUNT, 32'd0);
		cfg_write(REG_ADJ_PERIOD, 32'd0);
		send_tick(16'd100, 5'd12);
		send_tick(16'd0, 5'd12);
		send_tick(16'd101, 5'd5);
		send_tick(16'd0, 5'd5);
		drain_idle();
	endtask

	task automatic test_window_edges();
		// start not below end - 1: nothing is ever active
		cfg_write(REG_WINDOW_START, 32'd5);
		cfg_write(REG_WINDOW_END, 32'd6);
		send_tick(16'd7, 5'd5);
		send_tick(16'd9, 5'd6);
		drain_idle();
		// late window reaching past hour 23
		cfg_write(REG_WINDOW_START, 32'd23);
		cfg_write(REG_WINDOW_END, 32'd31);
		send_tick(16'd300, 5'd24);
		send_tick(16'd0, 5'd30);
		send_tick(16'd300, 5'd31);
		send_tick(16'd0, 5'd31);
		drain_idle();
		cfg_write(REG_WINDOW_START, 32'd0);
		cfg_write(REG_WINDOW_END, 32'd1);
		send_tick(16'hFFFF, 5'd0);
		send_tick(16'hFFFF, 5'd1);
		drain_idle();
	endtask

	task automatic test_level_ceiling();
		int i;
		cfg_write(REG_AVG_COUNT, 32'd1);
		cfg_write(REG_WINDOW_START, 32'd0);
		cfg_write(REG_WINDOW_END, 32'd24);
		cfg_write(REG_ADJ_PERIOD, 32'd1);
		for (i = 0; i < 290; i++) begin
			maybe_pause();
			send_tick(LUX_W'($urandom_range(300, 65535)),
				($urandom_range(0, 19) == 0) ? HOUR_W'($urandom_range(0, 31))
				                             : HOUR_W'($urandom_range(1, 23)));
		end
		drain_idle();
	endtask

	task automatic test_tick_saturation();
		int i;
		int h;
		cfg_write(REG_AVG_COUNT, 32'd4);
		cfg_write(REG_WINDOW_START, 32'd20);
		cfg_write(REG_WINDOW_END, 32'd22);
		cfg_write(REG_ADJ_PERIOD, 32'd255);
		for (i = 0; i < 264; i++) begin
			maybe_pause();
			h = $urandom_range(0, 30);
			if (h >= 21)
				h++;
			if (i >= 256)
				h = 21;
			send_tick(pick_lux(), HOUR_W'(h));
		end
		drain_idle();
	endtask

	task automatic test_random_settings();
		int p;
		int i;
		int s;
		int e;
		for (p = 0; p < 4; p++) begin
			case (p)
				0: cfg_write(REG_AVG_COUNT, 32'd16);
				1: cfg_write(REG_AVG_COUNT, 32'd31);
				default: cfg_write(REG_AVG_COUNT, $urandom_range(0, 16));
			endcase
			s = $urandom_range(0, 23);
			case ($urandom_range(0, 5))
				0: e = 31;
				1: e = $urandom_range(1, 24);
				default: begin
					e = s + 2 + $urandom_range(0, 8);
					if (e > 24)
						e = 24;
				end
			endcase
			cfg_write(REG_WINDOW_START, s);
			cfg_write(REG_WINDOW_END, e);
			case ($urandom_range(0, 5))
				0: cfg_write(REG_ADJ_PERIOD, 32'd0);
				1: cfg_write(REG_ADJ_PERIOD, 32'd1);
				default: cfg_write(REG_ADJ_PERIOD, $urandom_range(2, 6));
			endcase
			for (i = 0; i < 45; i++) begin
				maybe_pause();
				send_tick(pick_lux(), pick_hour());
			end
			drain_idle();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_window();
		test_wide_window();
		test_zero_settings();
		test_window_edges();
		test_level_ceiling();
		test_tick_saturation();
		test_random_settings();
		$display("ran %0d ticks across %0d register writes: %0d blanked beats, %0d level updates",
			n_ticks, n_writes, n_blank, n_steps);
		$display("highest light level reached %0d, mismatches %0d", peak_level, mismatches);
		if (mismatches == 0)
			$display("ambient_light_dimmer verification clean");
		else
			$display("ambient_light_dimmer verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d beats outstanding", pending_drive.size());
		$display("ambient_light_dimmer verification failed");
		$finish;
	end

endmodule
